// ===== hdl/sidasc_pkg.sv =====
// Shared constants and types for the signed integer to decimal ASCII converter.
package sidasc_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_W         = 6;
    localparam int LEN_W          = 4;
    localparam int SUM_W          = 5;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic bit_in;
        logic digit_shift;
    } t_dab_ctrl;

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Top level: converts a signed integer into a run of decimal ASCII characters.
//
// The input channel (i_valid / o_ready) takes one two's-complement value per
// transfer. The output channel (o_valid / i_ready) delivers one character per
// transfer, most significant first, with a leading '-' for negative values.
// Every character carries the total length of the text, and the final one
// carries o_last. Zero gives the single character '0'.
//
// After a transfer in, the magnitude is shifted into a BCD register one bit
// per cycle by the bit-serial shift-and-add-3 loop, then leading zero digits
// are dropped one per cycle, then one character is loaded per cycle while
// the output register is free. The next value is taken no earlier than the
// cycle after its predecessor's last character is loaded into the output
// register.
//
// A stalled receiver simply holds the output register; the converter waits
// until the register is free before loading the next character. Reset
// returns the controller to idle and empties the output register.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sidasc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sidasc_pkg::CHAR_W-1:0] o_character,
    output logic [sidasc_pkg::LEN_W-1:0]  o_length,
    output logic                          o_last
);

    // Digits of the largest magnitude, 2^(VALUE_BITS-1).
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int ND_W       = $clog2(NUM_DIGITS + 1);
    localparam int BC_W       = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [VALUE_BITS-1:0]         r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic [BC_W-1:0]               r_bcnt, n_bcnt;
    logic [ND_W-1:0]               r_nd, n_nd;
    logic [sidasc_pkg::LEN_W-1:0]  r_len, n_len;
    logic                          r_ovalid, n_ovalid;
    logic [sidasc_pkg::CHAR_W-1:0] r_char, n_char;
    logic [sidasc_pkg::LEN_W-1:0]  r_olen, n_olen;
    logic                          r_olast, n_olast;

    sidasc_pkg::t_dab_ctrl         w_ctrl;
    logic [3:0]                    w_top;
    logic                          w_in_xfer;
    logic                          w_out_free;
    logic [sidasc_pkg::SUM_W-1:0]  w_sum;

    sidasc_dabble #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_dabble (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .o_top  (w_top)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    // The output register can take a character when empty or being drained.
    assign w_out_free = !r_ovalid || i_ready;
    assign w_sum      = sidasc_pkg::SUM_W'(r_nd) + sidasc_pkg::SUM_W'(r_neg);

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_bcnt   = r_bcnt;
        n_nd     = r_nd;
        n_len    = r_len;
        n_char   = r_char;
        n_olen   = r_olen;
        n_olast  = r_olast;
        n_ovalid = r_ovalid && !i_ready;
        w_ctrl   = '0;
        w_ctrl.bit_in = r_mag[VALUE_BITS-1];

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    // The magnitude is taken unsigned, so the most negative
                    // value needs no special handling.
                    n_neg  = i_value[VALUE_BITS-1];
                    n_mag  = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_bcnt = BC_W'(VALUE_BITS - 1);
                    w_ctrl.clear = 1'b1;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctrl.bit_shift = 1'b1;
                n_mag  = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bcnt = r_bcnt - 1'b1;
                if (r_bcnt == '0) begin
                    n_nd    = ND_W'(NUM_DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, but always keep the units digit.
                if (r_nd == ND_W'(1) || w_top != 4'd0) begin
                    n_len   = w_sum[sidasc_pkg::LEN_W-1:0];
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end else begin
                    w_ctrl.digit_shift = 1'b1;
                    n_nd = r_nd - 1'b1;
                end
            end
            ST_SIGN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = sidasc_pkg::CH_MINUS;
                    n_olen   = r_len;
                    n_olast  = 1'b0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = sidasc_pkg::CH_ZERO + {2'b00, w_top};
                    n_olen   = r_len;
                    n_olast  = (r_nd == ND_W'(1));
                    w_ctrl.digit_shift = 1'b1;
                    n_nd = r_nd - 1'b1;
                    if (r_nd == ND_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_bcnt  <= n_bcnt;
        r_nd    <= n_nd;
        r_len   <= n_len;
        r_char  <= n_char;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_length    = r_olen;
    assign o_last      = r_olast;

    // Only the sign or a decimal digit ever leaves the block.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == sidasc_pkg::CH_MINUS ||
                     (o_character >= sidasc_pkg::CH_ZERO &&
                      o_character <= sidasc_pkg::CH_ZERO + 6'd9)))
        else $error("character out of range");

    // A sign is never the final character.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == sidasc_pkg::CH_MINUS |-> !o_last)
        else $error("sign marked last");

    // An accepted value always starts the bit-serial conversion.
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == ST_CONV)
        else $error("conversion did not start");

    // Emission never runs out of digits.
    a_emit_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT || r_state == ST_SKIP |-> r_nd != '0)
        else $error("digit count underflow");

endmodule

// ===== hdl/sidasc_dabble.sv =====
// BCD shift register: shift-and-add-3 conversion one bit per cycle, digit unload.
module sidasc_dabble #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                 i_clk,
    input  sidasc_pkg::t_dab_ctrl i_ctrl,
    output logic [3:0]           o_top
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_bcd;
    logic [BCD_W-1:0] w_adj;

    // Each digit of five or more gets three added before it is doubled.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        if (i_ctrl.clear) begin
            n_bcd = '0;
        end else if (i_ctrl.bit_shift) begin
            n_bcd = {w_adj[BCD_W-2:0], i_ctrl.bit_in};
        end else if (i_ctrl.digit_shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top = r_bcd[BCD_W-1 -: 4];

endmodule

// ===== test/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

    localparam int VB          = sidasc_pkg::VALUE_BITS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * VB + 40;
    localparam int CYCLE_LIMIT = 400000;

    // One expected character of the decimal text, with its side fields.
    typedef struct packed {
        logic [sidasc_pkg::CHAR_W-1:0] ch;
        logic [sidasc_pkg::LEN_W-1:0]  len;
        logic                          last;
    } t_text_char;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic signed [VB-1:0]          i_value = '0;
    logic                          i_ready = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic [sidasc_pkg::CHAR_W-1:0] o_character;
    logic [sidasc_pkg::LEN_W-1:0]  o_length;
    logic                          o_last;

    // Characters predicted for accepted values, oldest at the front.
    t_text_char expected_chars[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // Both sides stop idling while this is set.
    bit   quiet_mode = 1'b0;
    // Set by the hold-off process while the receiver refuses every transfer.
    bit   rx_hold = 1'b0;
    event hold_go;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_length    (o_length),
        .o_last      (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Works out the decimal text of one value. The magnitude is kept as an
    // unsigned quantity, so the most negative value yields 2^(VB-1) and
    // needs no special handling here.
    function automatic void predict_decimal_text(input logic signed [VB-1:0] value);
        logic [VB-1:0] magnitude;
        logic [3:0]    digit_buf[20];
        int            count;
        int            total;
        bit            negative;
        t_text_char    c;
        negative  = value[VB-1];
        magnitude = value;
        if (negative) begin
            magnitude = ~magnitude + 1'b1;
        end
        count = 0;
        do begin
            digit_buf[count] = 4'(magnitude % 10);
            magnitude        = VB'(magnitude / 10);
            count++;
        end while (magnitude != 0);
        total = count + (negative ? 1 : 0);
        if (negative) begin
            c.ch   = sidasc_pkg::CH_MINUS;
            c.len  = sidasc_pkg::LEN_W'(total);
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = count - 1; i >= 0; i--) begin
            c.ch   = sidasc_pkg::CH_ZERO + sidasc_pkg::CHAR_W'(digit_buf[i]);
            c.len  = sidasc_pkg::LEN_W'(total);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    // Only the first ten mismatches are printed; the rest are just counted.
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Offers one value and blocks until the block has taken it. The caller is
    // always at a rising edge, right after the previous transfer, so valid is
    // either held high for the next value or lowered for a gap, never both.
    task automatic send_value(input logic signed [VB-1:0] value);
        int gap;
        gap = 0;
        if (!quiet_mode && $urandom_range(99) < 25) begin
            gap = $urandom_range(20, 1);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        predict_decimal_text(value);
    endtask

    // Lowers valid and waits until every predicted character has come out.
    // At least one edge passes, so valid is never lowered and raised in the
    // same step.
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_chars.size() != 0);
    endtask

    // Random value whose magnitude has exactly the given number of digits.
    function automatic logic signed [VB-1:0] value_with_digits(input int num_digits);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mag;
        lo = 1;
        for (int i = 1; i < num_digits; i++) begin
            lo = lo * 10;
        end
        hi = (num_digits >= 10) ? 32'd2147483647 : lo * 10 - 1;
        if (num_digits == 1) begin
            lo = 0;
        end
        mag = $urandom_range(hi, lo);
        if ($urandom_range(1) == 1) begin
            return -$signed(mag);
        end
        return $signed(mag);
    endfunction

    // Extremes of the input range and the cases around digit boundaries:
    // zero, the single digits, powers of ten and the most negative value.
    task automatic test_directed();
        logic signed [VB-1:0] corner[$];
        corner = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                   999999999, 1000000000, -999999999, -1000000000,
                   123456789, -5, 2147483647, -2147483647, 32'h8000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corner[i]) begin
            send_value(corner[i]);
        end
    endtask

    // Every text length, for both signs.
    task automatic test_digit_counts();
        logic signed [VB-1:0] v;
        for (int n = 1; n <= 10; n++) begin
            v = value_with_digits(n);
            send_value(v);
            send_value(-v);
        end
    endtask

    // Random traffic: half full-range words, which toggle every input bit and
    // are mostly ten digits long, and half with a random digit count.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1) == 0) begin
                send_value($signed($urandom()));
            end else begin
                send_value(value_with_digits($urandom_range(10, 1)));
            end
        end
    endtask

    // The receiver refuses every transfer for a long stretch while values keep
    // coming, so the output register and then the input side back up.
    task automatic test_receiver_hold();
        -> hold_go;
        test_random(20);
        pause_until_drained();
    endtask

    // A long stretch in which neither side idles, to run at full rate.
    task automatic test_full_rate();
        quiet_mode = 1'b1;
        test_random(40);
        quiet_mode = 1'b0;
    endtask

    // The sender waits for an empty pipeline between short bursts.
    task automatic test_drained_bursts();
        for (int b = 0; b < 3; b++) begin
            test_random(3);
            pause_until_drained();
        end
    endtask

    // Receiver: checks each character transfer against the oldest prediction
    // and decides whether to accept in the next cycle.
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected character %0d length %0d last %0d",
                                            o_character, o_length, o_last));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_character !== want.ch) begin
                        note_mismatch($sformatf("character expected %0d got %0d",
                                                want.ch, o_character));
                    end
                    if (o_length !== want.len) begin
                        note_mismatch($sformatf("length expected %0d got %0d",
                                                want.len, o_length));
                    end
                    if (o_last !== want.last) begin
                        note_mismatch($sformatf("last expected %0d got %0d",
                                                want.last, o_last));
                    end
                end
            end
            i_ready <= !(rx_hold || (!quiet_mode && $urandom_range(99) < 6));
        end
    end

    // Counts out the receiver hold-off once it is requested.
    initial begin
        forever begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_digit_counts();
        test_random(110);
        test_receiver_hold();
        test_full_rate();
        test_drained_bursts();
        test_random(100);

        // Let the last characters out, then watch for stray ones.
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
